/* rtl/bmpd_pkg.sv */
`default_nettype none
package bmpd_pkg;

    localparam int unsigned ByteW  = 8;
    localparam int unsigned CountW = 11;

    // type bytes that open a packet
    localparam logic [ByteW-1:0] TYPE_HCI_EVENT = 8'h04;
    localparam logic [ByteW-1:0] TYPE_CTRL_RET  = 8'h26;
    localparam logic [ByteW-1:0] TYPE_INFO_RET  = 8'h21;
    localparam logic [ByteW-1:0] TYPE_DATA_PKT  = 8'h22;
    localparam logic [ByteW-1:0] TYPE_PHY_RET   = 8'h57;
    localparam logic [ByteW-1:0] TYPE_CMD_PKT   = 8'h27;

    // phy read return body is 4n+6 bytes
    localparam logic [CountW-1:0] PHY_EXTRA_BYTES = 11'd6;
    localparam logic [CountW-1:0] CTRL_RET_BODY   = 11'd2;

    typedef enum logic [2:0] {
        ST_TYPE     = 3'd0,
        ST_EVT_CODE = 3'd1,
        ST_EVT_LEN  = 3'd2,
        ST_CMD      = 3'd3,
        ST_LEN      = 3'd4,
        ST_LEN32    = 3'd5,
        ST_BODY     = 3'd6
    } parse_step_t;

    typedef struct packed {
        logic [ByteW-1:0]  byte_out;
        logic [CountW-1:0] byte_index;
        logic              byte_kept;
        logic              packet_done;
    } result_t;

endpackage
`default_nettype wire

/* rtl/bmpd_in_if.sv */
`default_nettype none
interface bmpd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface
`default_nettype wire

/* rtl/bmpd_out_if.sv */
`default_nettype none
interface bmpd_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  byte_out;
    logic [10:0] byte_index;
    logic        byte_kept;
    logic        packet_done;

    modport source (output valid, output byte_out, output byte_index,
                    output byte_kept, output packet_done, input ready);
    modport sink (input valid, input byte_out, input byte_index,
                  input byte_kept, input packet_done, output ready);
endinterface
`default_nettype wire

/* rtl/bmpd_parser.sv */
`default_nettype none
module bmpd_parser
    import bmpd_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             advance,
    input  wire logic [ByteW-1:0] rx_byte,
    output result_t               result
);

    parse_step_t       step_reg, step_next;
    logic [CountW-1:0] left_reg, left_next;
    logic [CountW-1:0] pos_reg, pos_next;
    logic [CountW-1:0] pos_cur;
    logic              kept;
    logic              done;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= ST_TYPE;
            left_reg <= '0;
            pos_reg  <= '0;
        end
        else if (advance)
        begin
            step_reg <= step_next;
            left_reg <= left_next;
            pos_reg  <= pos_next;
        end
    end

    always_comb
    begin
        step_next = step_reg;
        left_next = left_reg;
        pos_cur   = pos_reg;
        kept      = 1'b1;
        done      = 1'b0;
        unique case (step_reg) inside
            ST_EVT_CODE: step_next = ST_EVT_LEN;
            ST_CMD:      step_next = ST_LEN;
            ST_EVT_LEN, ST_LEN:
            begin
                if (rx_byte == '0)
                begin
                    done      = 1'b1;
                    step_next = ST_TYPE;
                end
                else
                begin
                    left_next = {{(CountW-ByteW){1'b0}}, rx_byte};
                    step_next = ST_BODY;
                end
            end
            ST_LEN32:
            begin
                left_next = {1'b0, rx_byte, 2'b00} + PHY_EXTRA_BYTES;
                step_next = ST_BODY;
            end
            ST_BODY:
            begin
                if (left_reg <= 11'd1)
                begin
                    left_next = '0;
                    done      = 1'b1;
                    step_next = ST_TYPE;
                end
                else
                begin
                    left_next = left_reg - 11'd1;
                end
            end
            default:
            begin
                // waiting for a type byte, unused code lands here too
                pos_cur = '0;
                unique case (rx_byte) inside
                    TYPE_HCI_EVENT: step_next = ST_EVT_CODE;
                    TYPE_CTRL_RET:
                    begin
                        left_next = CTRL_RET_BODY;
                        step_next = ST_BODY;
                    end
                    TYPE_INFO_RET, TYPE_CMD_PKT: step_next = ST_CMD;
                    TYPE_DATA_PKT:  step_next = ST_LEN;
                    TYPE_PHY_RET:   step_next = ST_LEN32;
                    default:
                    begin
                        kept      = 1'b0;
                        step_next = ST_TYPE;
                    end
                endcase
            end
        endcase

        pos_next           = kept ? pos_cur + 11'd1 : pos_cur;
        result.byte_out    = kept ? rx_byte : '0;
        result.byte_index  = kept ? pos_cur : '0;
        result.byte_kept   = kept;
        result.packet_done = done;
    end

endmodule
`default_nettype wire

/* rtl/ble_module_packet_deframer_unit.sv */
// packet deframer for bytes received from a radio module link
// each byte passes through the input register, then the parser into the result register
// throughput: one byte per cycle while out_ch.ready holds; parse state is a three-bit step and two 11-bit counters
// the result register frees itself in the same cycle it is taken, so no bubbles appear
// reset: asynchronous active low; parser waits for a type byte, both registers empty
`default_nettype none
module ble_module_packet_deframer_unit
    import bmpd_pkg::*;
(
    input wire logic   clk,
    input wire logic   rst_n,
    bmpd_in_if.sink    in_ch,
    bmpd_out_if.source out_ch
);

    // input register
    logic             s1_valid_reg;
    logic [ByteW-1:0] s1_byte_reg;

    // result register
    logic             out_valid_reg;
    result_t          out_data_reg;

    result_t          parsed;
    logic             out_free;
    logic             s1_advance;
    logic             in_take;

    // result register can load when empty or being taken this cycle
    assign out_free   = !out_valid_reg || out_ch.ready;
    // parser state moves only when its byte goes into the result register
    assign s1_advance = s1_valid_reg && out_free;
    assign in_ch.ready = !s1_valid_reg || out_free;
    assign in_take    = in_ch.valid && in_ch.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ch.ready)
            begin
                s1_valid_reg <= in_ch.valid;
            end
            if (out_free)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_byte_reg <= in_ch.rx_byte;
        end
        if (s1_advance)
        begin
            out_data_reg <= parsed;
        end
    end

    // state machine and counters for one byte
    bmpd_parser u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (s1_advance),
        .rx_byte (s1_byte_reg),
        .result  (parsed)
    );

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.byte_out    = out_data_reg.byte_out;
    assign out_ch.byte_index  = out_data_reg.byte_index;
    assign out_ch.byte_kept   = out_data_reg.byte_kept;
    assign out_ch.packet_done = out_data_reg.packet_done;

    // a dropped byte carries zero payload and never ends a packet
    a_drop_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_data_reg.byte_kept |->
            !out_data_reg.packet_done && out_data_reg.byte_index == '0
            && out_data_reg.byte_out == '0)
        else $error("dropped byte with nonzero payload or done flag");

    // a type byte never completes a packet
    a_type_not_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_data_reg.byte_kept && out_data_reg.byte_index == '0 |->
            !out_data_reg.packet_done)
        else $error("type byte marked as packet end");

    // input stalls only while the input register holds a byte
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ch.ready |-> s1_valid_reg && out_valid_reg)
        else $error("input stalled without a held byte");

endmodule
`default_nettype wire
